// File: hdl/buddy_block_allocator_unit_macros.svh
// Assertion macros shared by the buddy allocator modules.
// Depends on nothing; every user must have clk and arst_n in scope.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// File: hdl/bba_pkg.sv
// Shared types, codes and defaults for the buddy block allocator.
// Used by the controller, the datapath and the top level.
package bba_pkg;

	localparam int MIN_RANK_DEF     = 5;
	localparam int MAX_RANK_DEF     = 16;
	localparam int HEADER_BYTES_DEF = 8;
	localparam int RANK_W           = 5;
	localparam int MAX_RANK_RESET   = 16;

	localparam logic       CFG_FIT_MODE = 1'b0;
	localparam logic       CFG_MAX_RANK = 1'b1;
	localparam logic [1:0] FIT_WORST    = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_MEMORY  = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR   = 2'd2;
	localparam logic [1:0] ST_ALREADY_FR = 2'd3;

	typedef struct packed {
		logic        action;
		logic [15:0] request_bytes;
		logic [15:0] free_offset;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [15:0]       user_offset;
		logic [RANK_W-1:0] granted_rank;
	} out_item_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              used;
		logic              start;
	} granule_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECODE, S_SEARCH, S_POP, S_SPLIT, S_FREE_CHK,
		S_BUDDY, S_BUD_CHK, S_WALK, S_WALK_NX, S_FIX, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_ACCEPT, OP_SEARCH_INIT, OP_SEARCH, OP_POP_RD, OP_POP,
		OP_SPLIT, OP_ALLOC_FIN, OP_RD_G, OP_TAKE_RANK, OP_RD_BUDDY, OP_WALK_INIT,
		OP_RD_LINK, OP_WALK_NX, OP_FIX, OP_MERGE, OP_PUSH, OP_OOM, OP_BAD, OP_FREED
	} op_t;

	typedef struct packed {
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic reinit;
		logic out_free;
		logic is_alloc;
		logic need_ok;
		logic bad_range;
		logic is_worst;
		logic head_hit;
		logic search_end;
		logic split_more;
		logic g_start;
		logic g_used;
		logic at_top;
		logic bud_ok;
		logic cur_hit;
		logic walk_stop;
	} sts_t;

endpackage

// File: hdl/bba_ctrl.sv
// Sequencer of the buddy block allocator: walks allocate and free operations.
// Depends on bba_pkg and the assertion macro header.
`include "buddy_block_allocator_unit_macros.svh"

module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);

	bba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd.op       = bba_pkg::OP_NONE;
		cmd.out_load = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			bba_pkg::S_CLEAR: begin
				cmd.op = bba_pkg::OP_CLEAR;
				if (sts.clear_last) state_d = bba_pkg::S_IDLE;
			end
			bba_pkg::S_IDLE: begin
				in_ready = !sts.reinit;
				if (in_valid && !sts.reinit) begin
					cmd.op  = bba_pkg::OP_ACCEPT;
					state_d = bba_pkg::S_DECODE;
				end
			end
			bba_pkg::S_DECODE: begin
				priority if (sts.is_alloc && !sts.need_ok) begin
					cmd.op  = bba_pkg::OP_OOM;
					state_d = bba_pkg::S_DONE;
				end else if (sts.is_alloc) begin
					cmd.op  = bba_pkg::OP_SEARCH_INIT;
					state_d = bba_pkg::S_SEARCH;
				end else if (sts.bad_range) begin
					cmd.op  = bba_pkg::OP_BAD;
					state_d = bba_pkg::S_DONE;
				end else begin
					cmd.op  = bba_pkg::OP_RD_G;
					state_d = bba_pkg::S_FREE_CHK;
				end
			end
			bba_pkg::S_SEARCH: begin
				priority if (sts.head_hit) begin
					cmd.op  = bba_pkg::OP_POP_RD;
					state_d = bba_pkg::S_POP;
				end else if (sts.search_end) begin
					cmd.op  = bba_pkg::OP_OOM;
					state_d = bba_pkg::S_DONE;
				end else begin
					cmd.op = bba_pkg::OP_SEARCH;
				end
			end
			bba_pkg::S_POP: begin
				cmd.op  = bba_pkg::OP_POP;
				state_d = bba_pkg::S_SPLIT;
			end
			bba_pkg::S_SPLIT: begin
				if (sts.split_more) begin
					cmd.op = bba_pkg::OP_SPLIT;
				end else begin
					cmd.op  = bba_pkg::OP_ALLOC_FIN;
					state_d = bba_pkg::S_DONE;
				end
			end
			bba_pkg::S_FREE_CHK: begin
				priority if (!sts.g_start) begin
					cmd.op  = bba_pkg::OP_BAD;
					state_d = bba_pkg::S_DONE;
				end else if (!sts.g_used) begin
					cmd.op  = bba_pkg::OP_FREED;
					state_d = bba_pkg::S_DONE;
				end else begin
					cmd.op  = bba_pkg::OP_TAKE_RANK;
					state_d = bba_pkg::S_BUDDY;
				end
			end
			bba_pkg::S_BUDDY: begin
				if (sts.at_top) begin
					cmd.op  = bba_pkg::OP_PUSH;
					state_d = bba_pkg::S_DONE;
				end else begin
					cmd.op  = bba_pkg::OP_RD_BUDDY;
					state_d = bba_pkg::S_BUD_CHK;
				end
			end
			bba_pkg::S_BUD_CHK: begin
				if (sts.bud_ok) begin
					cmd.op  = bba_pkg::OP_WALK_INIT;
					state_d = bba_pkg::S_WALK;
				end else begin
					cmd.op  = bba_pkg::OP_PUSH;
					state_d = bba_pkg::S_DONE;
				end
			end
			bba_pkg::S_WALK: begin
				priority if (sts.cur_hit) begin
					cmd.op  = bba_pkg::OP_RD_LINK;
					state_d = bba_pkg::S_FIX;
				end else if (sts.walk_stop) begin
					// The buddy is not on its list; the merge goes ahead regardless.
					cmd.op  = bba_pkg::OP_MERGE;
					state_d = bba_pkg::S_BUDDY;
				end else begin
					cmd.op  = bba_pkg::OP_RD_LINK;
					state_d = bba_pkg::S_WALK_NX;
				end
			end
			bba_pkg::S_WALK_NX: begin
				cmd.op  = bba_pkg::OP_WALK_NX;
				state_d = bba_pkg::S_WALK;
			end
			bba_pkg::S_FIX: begin
				cmd.op  = bba_pkg::OP_FIX;
				state_d = bba_pkg::S_BUDDY;
			end
			bba_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = bba_pkg::S_IDLE;
				end
			end
			default: state_d = bba_pkg::S_CLEAR;
		endcase
		if (sts.reinit) state_d = bba_pkg::S_CLEAR;
	end

	`BBA_ASSERT_SAME(a_load_free, cmd.out_load, sts.out_free, "result loaded over an untaken one")
	`BBA_ASSERT_NEXT(a_accept_dec, in_valid && in_ready, state_q == bba_pkg::S_DECODE,
		"accepted item did not go to decode")
	`BBA_ASSERT_NEXT(a_reinit_clr, sts.reinit, state_q == bba_pkg::S_CLEAR,
		"size change did not start a clearing pass")

endmodule

// File: hdl/bba_dpath.sv
// Datapath of the buddy block allocator: granule and link memories, free list
// heads, configuration and result registers. Depends on bba_pkg and the macro header.
`include "buddy_block_allocator_unit_macros.svh"

module bba_dpath #(
	parameter int MIN_RANK     = bba_pkg::MIN_RANK_DEF,
	parameter int MAX_RANK     = bba_pkg::MAX_RANK_DEF,
	parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data,
	input  bba_pkg::in_item_t  in_data,
	input  bba_pkg::cmd_t      cmd,
	output bba_pkg::sts_t      sts,
	output logic               out_valid,
	input  logic               out_ready,
	output bba_pkg::out_item_t out_data
);

	localparam int RW     = bba_pkg::RANK_W;
	localparam int NLISTS = MAX_RANK - MIN_RANK + 1;
	localparam int LW     = (NLISTS > 1) ? $clog2(NLISTS) : 1;
	localparam int GW     = (MAX_RANK > MIN_RANK) ? (MAX_RANK - MIN_RANK) : 1;
	localparam int NGRAN  = 1 << (MAX_RANK - MIN_RANK);
	localparam int RST_R  = (bba_pkg::MAX_RANK_RESET > MAX_RANK) ? MAX_RANK :
		(bba_pkg::MAX_RANK_RESET < MIN_RANK) ? MIN_RANK : bba_pkg::MAX_RANK_RESET;

	// Configuration.
	logic [1:0]    fit_q;
	logic [RW-1:0] maxr_q, cfg_rank;
	logic          reinit;

	// Operation registers.
	logic          act_q, bad_q;
	logic [RW-1:0] need_q, rank_q;
	logic [GW-1:0] g_q, b_q, cur_q, prev_q, clr_q;
	logic          have_cur_q, have_prev_q;
	logic [GW:0]   n_q;
	bba_pkg::out_item_t res_q, out_q;
	logic          out_valid_q;

	// Free list heads.
	logic [GW-1:0] head_q [NLISTS];
	logic          hval_q [NLISTS];

	// Memories and their ports.
	bba_pkg::granule_t gmem [NGRAN];
	logic [GW:0]       lmem [NGRAN];
	bba_pkg::granule_t grd_q, gm_wd;
	logic [GW:0]       lrd_q, lm_wd;
	logic              gm_we, gm_re, lm_we, lm_re;
	logic [GW-1:0]     gm_wa, gm_ra, lm_wa, lm_ra;

	// Derived values.
	logic [RW-1:0] rdiff, rdm1, rdmax, take_rank;
	logic [LW-1:0] li, lim1;
	logic [GW-1:0] split_h, buddy, merge_dst;
	logic [31:0]   uoff32;
	logic [16:0]   total, tm1;
	logic [RW-1:0] blen, need_c;
	logic [15:0]   blk;
	logic [31:0]   blk32;
	logic          bad_c;
	logic [GW-1:0] g_c;

	always_comb begin
		rdiff     = rank_q - RW'(MIN_RANK);
		rdm1      = rank_q - RW'(MIN_RANK + 1);
		rdmax     = maxr_q - RW'(MIN_RANK);
		li        = rdiff[LW-1:0];
		lim1      = rdm1[LW-1:0];
		split_h   = g_q + (GW'(1) << rdm1);
		buddy     = g_q ^ (GW'(1) << rdiff);
		merge_dst = (b_q < g_q) ? g_q : b_q;
		uoff32    = (32'(g_q) << MIN_RANK) + 32'(HEADER_BYTES);
		take_rank = grd_q.rank;
		if (take_rank > maxr_q) take_rank = maxr_q;
		if (take_rank < RW'(MIN_RANK)) take_rank = RW'(MIN_RANK);
	end

	// Size of an allocate request as a rank, and range checks of a free offset.
	always_comb begin
		total = {1'b0, in_data.request_bytes} + 17'(HEADER_BYTES);
		tm1   = total - 17'd1;
		blen  = '0;
		for (int i = 0; i < 17; i++) begin
			if (tm1[i]) blen = RW'(i + 1);
		end
		need_c = (total <= 17'(1 << MIN_RANK)) ? RW'(MIN_RANK) : blen;
		blk    = in_data.free_offset - 16'(HEADER_BYTES);
		blk32  = 32'(blk);
		bad_c  = (in_data.free_offset < 16'(HEADER_BYTES)) || ((blk32 >> maxr_q) != 32'd0) ||
			(blk32[MIN_RANK-1:0] != '0);
		g_c    = blk32[MIN_RANK +: GW];
	end

	always_comb begin
		cfg_rank = cfg_data;
		if (cfg_rank < RW'(MIN_RANK)) cfg_rank = RW'(MIN_RANK);
		if (cfg_rank > RW'(MAX_RANK)) cfg_rank = RW'(MAX_RANK);
		reinit = cfg_write && (cfg_index == bba_pkg::CFG_MAX_RANK);
	end

	// Memory port selection.
	always_comb begin
		gm_we = 1'b0;
		gm_wa = g_q;
		gm_wd = '0;
		gm_re = 1'b0;
		gm_ra = g_q;
		lm_we = 1'b0;
		lm_wa = g_q;
		lm_wd = '0;
		lm_re = 1'b0;
		lm_ra = cur_q;
		unique case (cmd.op)
			bba_pkg::OP_CLEAR: begin
				gm_we = 1'b1;
				gm_wa = clr_q;
				if (clr_q == '0) begin
					gm_wd = '{rank: maxr_q, used: 1'b0, start: 1'b1};
					lm_we = 1'b1;
					lm_wa = clr_q;
				end
			end
			bba_pkg::OP_POP_RD: begin
				lm_re = 1'b1;
				lm_ra = head_q[li];
			end
			bba_pkg::OP_SPLIT: begin
				gm_we = 1'b1;
				gm_wa = split_h;
				gm_wd = '{rank: rank_q - RW'(1), used: 1'b0, start: 1'b1};
				lm_we = 1'b1;
				lm_wa = split_h;
				lm_wd = {hval_q[lim1], head_q[lim1]};
			end
			bba_pkg::OP_ALLOC_FIN: begin
				gm_we = 1'b1;
				gm_wd = '{rank: need_q, used: 1'b1, start: 1'b1};
				lm_we = 1'b1;
			end
			bba_pkg::OP_RD_G: gm_re = 1'b1;
			bba_pkg::OP_RD_BUDDY: begin
				gm_re = 1'b1;
				gm_ra = buddy;
			end
			bba_pkg::OP_RD_LINK: lm_re = 1'b1;
			bba_pkg::OP_FIX, bba_pkg::OP_MERGE: begin
				// The upper of the two halves stops being a block start.
				gm_we = 1'b1;
				gm_wa = merge_dst;
				gm_wd = '{rank: rank_q, used: 1'b0, start: 1'b0};
				if (cmd.op == bba_pkg::OP_FIX && have_prev_q) begin
					lm_we = 1'b1;
					lm_wa = prev_q;
					lm_wd = lrd_q;
				end
			end
			bba_pkg::OP_PUSH: begin
				gm_we = 1'b1;
				gm_wd = '{rank: rank_q, used: 1'b0, start: 1'b1};
				lm_we = 1'b1;
				lm_wd = {hval_q[li], head_q[li]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (gm_we) gmem[gm_wa] <= gm_wd;
		if (gm_re) grd_q <= gmem[gm_ra];
	end

	always_ff @(posedge clk) begin
		if (lm_we) lmem[lm_wa] <= lm_wd;
		if (lm_re) lrd_q <= lmem[lm_ra];
	end

	// Control state: configuration, clearing counter, list valid bits, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q       <= '0;
			maxr_q      <= RW'(RST_R);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NLISTS; k++) hval_q[k] <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == bba_pkg::CFG_FIT_MODE) fit_q <= cfg_data[1:0];
			if (reinit) maxr_q <= cfg_rank;
			if (reinit) begin
				clr_q <= '0;
			end else if (cmd.op == bba_pkg::OP_CLEAR) begin
				clr_q <= clr_q + GW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				bba_pkg::OP_CLEAR: begin
					if (clr_q == '0) begin
						for (int k = 0; k < NLISTS; k++) hval_q[k] <= (rdmax == RW'(k));
					end
				end
				bba_pkg::OP_POP: hval_q[li] <= lrd_q[GW];
				bba_pkg::OP_SPLIT: hval_q[lim1] <= 1'b1;
				bba_pkg::OP_FIX: if (!have_prev_q) hval_q[li] <= lrd_q[GW];
				bba_pkg::OP_PUSH: hval_q[li] <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.out_load) out_q <= res_q;
		unique case (cmd.op)
			bba_pkg::OP_CLEAR: begin
				if (clr_q == '0) begin
					for (int k = 0; k < NLISTS; k++) head_q[k] <= '0;
				end
			end
			bba_pkg::OP_ACCEPT: begin
				act_q  <= in_data.action;
				need_q <= need_c;
				bad_q  <= bad_c;
				g_q    <= g_c;
			end
			bba_pkg::OP_SEARCH_INIT: rank_q <= (fit_q == bba_pkg::FIT_WORST) ? maxr_q : need_q;
			bba_pkg::OP_SEARCH: begin
				rank_q <= (fit_q == bba_pkg::FIT_WORST) ? rank_q - RW'(1) : rank_q + RW'(1);
			end
			bba_pkg::OP_POP_RD: g_q <= head_q[li];
			bba_pkg::OP_POP: head_q[li] <= lrd_q[GW-1:0];
			bba_pkg::OP_SPLIT: begin
				head_q[lim1] <= split_h;
				rank_q       <= rank_q - RW'(1);
			end
			bba_pkg::OP_ALLOC_FIN: res_q <= '{status: bba_pkg::ST_OK,
				user_offset: uoff32[15:0], granted_rank: need_q};
			bba_pkg::OP_TAKE_RANK: rank_q <= take_rank;
			bba_pkg::OP_RD_BUDDY: b_q <= buddy;
			bba_pkg::OP_WALK_INIT: begin
				cur_q       <= head_q[li];
				have_cur_q  <= hval_q[li];
				have_prev_q <= 1'b0;
				n_q         <= '0;
			end
			bba_pkg::OP_WALK_NX: begin
				prev_q      <= cur_q;
				have_prev_q <= 1'b1;
				cur_q       <= lrd_q[GW-1:0];
				have_cur_q  <= lrd_q[GW];
				n_q         <= n_q + (GW+1)'(1);
			end
			bba_pkg::OP_FIX, bba_pkg::OP_MERGE: begin
				if (cmd.op == bba_pkg::OP_FIX && !have_prev_q) head_q[li] <= lrd_q[GW-1:0];
				if (b_q < g_q) g_q <= b_q;
				rank_q <= rank_q + RW'(1);
			end
			bba_pkg::OP_PUSH: begin
				head_q[li] <= g_q;
				res_q      <= '{status: bba_pkg::ST_OK, user_offset: 16'd0, granted_rank: rank_q};
			end
			bba_pkg::OP_OOM: res_q <= '{status: bba_pkg::ST_NO_MEMORY, user_offset: 16'd0,
				granted_rank: '0};
			bba_pkg::OP_BAD: res_q <= '{status: bba_pkg::ST_BAD_ADDR, user_offset: 16'd0,
				granted_rank: '0};
			bba_pkg::OP_FREED: res_q <= '{status: bba_pkg::ST_ALREADY_FR, user_offset: 16'd0,
				granted_rank: '0};
			default: ;
		endcase
	end

	always_comb begin
		sts.clear_last = (clr_q == GW'(NGRAN - 1));
		sts.reinit     = reinit;
		sts.out_free   = !out_valid_q || out_ready;
		sts.is_alloc   = !act_q;
		sts.need_ok    = (need_q <= maxr_q);
		sts.bad_range  = bad_q;
		sts.is_worst   = (fit_q == bba_pkg::FIT_WORST);
		sts.head_hit   = hval_q[li];
		sts.search_end = sts.is_worst ? (rank_q == need_q) : (rank_q == maxr_q);
		sts.split_more = (rank_q > need_q);
		sts.g_start    = grd_q.start;
		sts.g_used     = grd_q.used;
		sts.at_top     = (rank_q >= maxr_q);
		sts.bud_ok     = grd_q.start && !grd_q.used && (grd_q.rank == rank_q);
		sts.cur_hit    = have_cur_q && (cur_q == b_q);
		sts.walk_stop  = !have_cur_q || (n_q == (GW+1)'(NGRAN));
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`BBA_ASSERT_SAME(a_search_rng, cmd.op == bba_pkg::OP_SEARCH,
		(rank_q >= RW'(MIN_RANK)) && (rank_q < maxr_q || sts.is_worst), "search left the ranks")
	`BBA_ASSERT_SAME(a_split_rank, cmd.op == bba_pkg::OP_SPLIT, rank_q > need_q,
		"split below the needed rank")

endmodule

// File: hdl/buddy_block_allocator_unit.sv
// An allocate searches the free lists and then splits; a free checks its granule, then
// merges with its buddy rank by rank, walking the buddy's free list over the link memory.
// The block takes one item at a time and accepts no new item until its result is loaded.
// Reset, and any write of max_rank, runs a clearing pass over the granule memory,
// during which no item is taken.
// Depends on bba_pkg, bba_ctrl and bba_dpath.
module buddy_block_allocator_unit #(
	parameter int MIN_RANK     = bba_pkg::MIN_RANK_DEF,
	parameter int MAX_RANK     = bba_pkg::MAX_RANK_DEF,
	parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  bba_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bba_pkg::out_item_t out_data
);

	bba_pkg::cmd_t cmd;
	bba_pkg::sts_t sts;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bba_dpath #(
		.MIN_RANK     (MIN_RANK),
		.MAX_RANK     (MAX_RANK),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: verif/bba_checker.sv
// Checker for the buddy block allocator: mirrors the free lists and granule table,
// predicts one result per accepted request and compares results as they transfer.
// Depends on bba_pkg; watches the configuration port and both channels of the block.
module bba_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  bba_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  bba_pkg::out_item_t out_data,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MIN_R  = bba_pkg::MIN_RANK_DEF;
	localparam int MAX_R  = bba_pkg::MAX_RANK_DEF;
	localparam int HDR_B  = bba_pkg::HEADER_BYTES_DEF;
	localparam int NLISTS = MAX_R - MIN_R + 1;
	localparam int NGRAN  = 1 << (MAX_R - MIN_R);

	logic [10:0] head [NLISTS];
	logic        head_v [NLISTS];
	logic [10:0] link [NGRAN];
	logic        link_v [NGRAN];
	logic [4:0]  g_rank [NGRAN];
	logic        g_used [NGRAN];
	logic        g_start [NGRAN];
	logic [1:0]  fit;
	int          mem_rank;
	bba_pkg::out_item_t expected_results [$];

	assign pending = expected_results.size();

	function automatic void clear_memory();
		for (int i = 0; i < NLISTS; i++) begin
			head[i] = '0;
			head_v[i] = 1'b0;
		end
		for (int i = 0; i < NGRAN; i++) begin
			link[i] = '0;
			link_v[i] = 1'b0;
			g_rank[i] = '0;
			g_used[i] = 1'b0;
			g_start[i] = 1'b0;
		end
		g_rank[0] = 5'(mem_rank);
		g_start[0] = 1'b1;
		head[mem_rank - MIN_R] = '0;
		head_v[mem_rank - MIN_R] = 1'b1;
	endfunction

	function automatic void push_free(int g, int rank);
		int li;
		li = rank - MIN_R;
		g_used[g] = 1'b0;
		g_rank[g] = 5'(rank);
		g_start[g] = 1'b1;
		link[g] = head[li];
		link_v[g] = head_v[li];
		head[li] = 11'(g);
		head_v[li] = 1'b1;
	endfunction

	function automatic void unlink_free(int g, int rank);
		int li;
		int cur;
		int prev;
		bit have_cur;
		bit have_prev;
		li = rank - MIN_R;
		prev = 0;
		have_prev = 0;
		have_cur = head_v[li];
		cur = int'(head[li]);
		for (int n = 0; n < NGRAN && have_cur && cur != g; n++) begin
			prev = cur;
			have_prev = 1;
			have_cur = link_v[cur];
			cur = int'(link[cur]);
		end
		if (!have_cur || cur != g)
			return;
		if (have_prev) begin
			link[prev] = link[cur];
			link_v[prev] = link_v[cur];
		end else begin
			head[li] = link[cur];
			head_v[li] = link_v[cur];
		end
	endfunction

	function automatic bba_pkg::out_item_t allocator_result(bba_pkg::in_item_t it);
		bba_pkg::out_item_t res;
		int total;
		int need;
		int sel;
		int g;
		int off;
		int blk;
		int rank;
		int b;
		bit found;
		res = '0;
		found = 0;
		sel = 0;
		if (!it.action) begin
			total = int'(it.request_bytes) + HDR_B;
			need = MIN_R;
			while (need < 31 && (longint'(1) << need) < total)
				need++;
			if (need <= mem_rank) begin
				if (fit == bba_pkg::FIT_WORST) begin
					for (int r = mem_rank; r >= need && !found; r--)
						if (head_v[r - MIN_R]) begin
							sel = r;
							found = 1;
						end
				end else begin
					for (int r = need; r <= mem_rank && !found; r++)
						if (head_v[r - MIN_R]) begin
							sel = r;
							found = 1;
						end
				end
			end
			if (!found) begin
				res.status = bba_pkg::ST_NO_MEMORY;
			end else begin
				g = int'(head[sel - MIN_R]);
				unlink_free(g, sel);
				while (sel > need) begin
					sel--;
					push_free(g + (1 << (sel - MIN_R)), sel);
				end
				g_used[g] = 1'b1;
				g_rank[g] = 5'(need);
				g_start[g] = 1'b1;
				link_v[g] = 1'b0;
				link[g] = '0;
				res.status = bba_pkg::ST_OK;
				res.user_offset = 16'((g << MIN_R) + HDR_B);
				res.granted_rank = 5'(need);
			end
		end else begin
			off = int'(it.free_offset);
			blk = off - HDR_B;
			if (off < HDR_B || blk >= (1 << mem_rank) ||
			    (blk & ((1 << MIN_R) - 1)) != 0) begin
				res.status = bba_pkg::ST_BAD_ADDR;
			end else begin
				g = blk >> MIN_R;
				if (!g_start[g]) begin
					res.status = bba_pkg::ST_BAD_ADDR;
				end else if (!g_used[g]) begin
					res.status = bba_pkg::ST_ALREADY_FR;
				end else begin
					rank = int'(g_rank[g]);
					if (rank > mem_rank) rank = mem_rank;
					if (rank < MIN_R) rank = MIN_R;
					g_used[g] = 1'b0;
					while (rank < mem_rank) begin
						b = g ^ (1 << (rank - MIN_R));
						if (b >= (1 << (mem_rank - MIN_R)) || !g_start[b] ||
						    g_used[b] || int'(g_rank[b]) != rank)
							break;
						unlink_free(b, rank);
						if (b < g) begin
							g_start[g] = 1'b0;
							g = b;
						end else begin
							g_start[b] = 1'b0;
						end
						rank++;
						g_rank[g] = 5'(rank);
						g_used[g] = 1'b0;
					end
					push_free(g, rank);
					res.status = bba_pkg::ST_OK;
					res.granted_rank = 5'(rank);
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bba_pkg::out_item_t want;
		if (!arst_n) begin
			fit = '0;
			mem_rank = bba_pkg::MAX_RANK_RESET;
			clear_memory();
			expected_results.delete();
			errors = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == bba_pkg::CFG_FIT_MODE) begin
					fit = cfg_data[1:0];
				end else begin
					mem_rank = int'(cfg_data);
					if (mem_rank < MIN_R) mem_rank = MIN_R;
					if (mem_rank > MAX_R) mem_rank = MAX_R;
					clear_memory();
				end
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %p", $time, out_data);
				end else begin
					want = expected_results.pop_front();
					if (out_data.status !== want.status ||
					    out_data.user_offset !== want.user_offset ||
					    out_data.granted_rank !== want.granted_rank) begin
						errors++;
						$display({"%0t: mismatch, expected status %0d offset %0d rank %0d,",
							" actual status %0d offset %0d rank %0d"},
							$time, want.status, want.user_offset, want.granted_rank,
							out_data.status, out_data.user_offset, out_data.granted_rank);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.insert(expected_results.size(), allocator_result(in_data));
		end
	end

endmodule

// File: verif/tb.sv
// Top of the buddy allocator testbench: clock, reset, requests and configuration phases.
// Depends on bba_pkg, buddy_block_allocator_unit and bba_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	logic      clk;
	logic      arst_n;
	logic      cfg_write;
	logic      cfg_index;
	logic [4:0] cfg_data;
	logic      in_valid;
	logic      in_ready;
	bba_pkg::in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	bba_pkg::out_item_t out_data;
	int        errors;
	int        pending;
	int        cycles = 0;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        mem_rank;
	logic [15:0] live_offsets [$];
	logic [15:0] freed_offsets [$];

	buddy_block_allocator_unit dut (.*);

	bba_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Successful allocations are the only results with a non-zero offset.
	always @(posedge clk)
		if (out_valid && out_ready && out_data.status == bba_pkg::ST_OK &&
		    out_data.user_offset != 0)
			live_offsets.insert(live_offsets.size(), out_data.user_offset);

	task automatic send(logic act, logic [15:0] req, logic [15:0] off);
		bba_pkg::in_item_t it;
		it.action = act;
		it.request_bytes = req;
		it.free_offset = off;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic free_live();
		int k;
		logic [15:0] off;
		k = $urandom_range(0, live_offsets.size() - 1);
		off = live_offsets[k];
		live_offsets.delete(k);
		freed_offsets.insert(freed_offsets.size(), off);
		send(1'b1, 16'($urandom), off);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Both registers are written back to back; the write enable drops after the second.
	task automatic reconfigure(logic [4:0] fit_val, logic [4:0] rank_val);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= bba_pkg::CFG_FIT_MODE;
		cfg_data <= fit_val;
		@(negedge clk);
		cfg_index <= bba_pkg::CFG_MAX_RANK;
		cfg_data <= rank_val;
		@(negedge clk);
		cfg_write <= 1'b0;
		mem_rank = (rank_val < bba_pkg::MIN_RANK_DEF) ? bba_pkg::MIN_RANK_DEF :
			(rank_val > bba_pkg::MAX_RANK_DEF) ? bba_pkg::MAX_RANK_DEF : int'(rank_val);
		live_offsets.delete();
		freed_offsets.delete();
	endtask

	task automatic random_item();
		int pick;
		int slots;
		logic [15:0] req;
		logic [15:0] off;
		pick = $urandom_range(0, 99);
		slots = 1 << (mem_rank - bba_pkg::MIN_RANK_DEF);
		if (pick < 70)
			req = 16'($urandom_range(0, (1 << mem_rank) / 6));
		else if (pick < 90)
			req = 16'($urandom_range(0, 64));
		else
			req = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (live_offsets.size() > 0 && pick < 45) begin
			free_live();
		end else if (pick < 55) begin
			if (pick < 49 && freed_offsets.size() > 0)
				off = freed_offsets[$urandom_range(0, freed_offsets.size() - 1)];
			else if (pick < 52)
				off = 16'(($urandom_range(0, slots - 1) << bba_pkg::MIN_RANK_DEF) +
					bba_pkg::HEADER_BYTES_DEF);
			else
				off = 16'($urandom);
			send(1'b1, 16'($urandom), off);
		end else begin
			send(1'b0, req, 16'($urandom));
		end
	endtask

	initial begin
		logic [4:0] fit_plan [6];
		logic [4:0] rank_plan [6];
		fit_plan = '{5'd0, 5'd2, 5'd1, 5'd7, 5'd2, 5'd0};
		rank_plan = '{5'd16, 5'd3, 5'd10, 5'd31, 5'd16, 5'd8};
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 71;
		mem_rank = bba_pkg::MAX_RANK_RESET;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed requests at the reset configuration.
		send(1'b0, 16'd24, 16'hffff);
		send(1'b0, 16'd25, 16'h0000);
		send(1'b0, 16'd1000, 16'h0000);
		send(1'b0, 16'd0, 16'h0000);
		send(1'b1, 16'hffff, 16'd0);
		send(1'b1, 16'h0000, 16'd7);
		send(1'b1, 16'h0000, 16'hffff);
		send(1'b1, 16'h0000, 16'd9);
		drain();
		send(1'b1, 16'h0000, 16'd8);
		send(1'b1, 16'h0000, 16'd8);
		send(1'b1, 16'h0000, 16'd72);
		send(1'b0, 16'd65528, 16'h0000);
		send(1'b0, 16'd65535, 16'h0000);
		send(1'b0, 16'd65529, 16'h0000);
		drain();
		while (live_offsets.size() > 0)
			free_live();
		drain();
		send(1'b0, 16'd65528, 16'h0000);
		drain();
		while (live_offsets.size() > 0)
			free_live();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph >= 1)
				reconfigure(fit_plan[ph], rank_plan[ph]);
			send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 71 : 0;
			recv_idle_pct = (ph < 2) ? 71 : (ph < 4) ? 33 : 0;
			for (int n = 0; n < 90; n++)
				random_item();
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ctrl.sv
hdl/bba_dpath.sv
hdl/buddy_block_allocator_unit.sv
verif/bba_checker.sv
verif/tb.sv
